>>> hw/rtl/sts_pkg.sv
`default_nettype none

package sts_pkg;

    localparam int POSITION_BITS = 16;
    localparam int LINE_BITS     = 16;
    localparam int FIELD_BITS    = 16;
    localparam int FIELD_MAX     = 65535;
    localparam int MAX_TOKENS    = 3;
    localparam int COUNT_BITS    = $clog2(MAX_TOKENS + 1);
    localparam int QUEUE_DEPTH   = 4;
    localparam int QUEUE_AW      = $clog2(QUEUE_DEPTH);
    localparam int POS_EXT_W     = (POSITION_BITS + 1 > FIELD_BITS + 1) ?
                                   POSITION_BITS + 1 : FIELD_BITS + 1;
    localparam int LINE_EXT_W    = (LINE_BITS > FIELD_BITS + 1) ? LINE_BITS : FIELD_BITS + 1;

    typedef logic [POSITION_BITS-1:0] t_pos;
    typedef logic [LINE_BITS-1:0]     t_line;
    typedef logic [FIELD_BITS-1:0]    t_field;
    typedef logic [4:0]               t_kind;
    typedef logic [COUNT_BITS-1:0]    t_count;
    typedef logic [1:0]               t_oper;

    localparam t_kind K_LPAREN    = 5'd0;
    localparam t_kind K_RPAREN    = 5'd1;
    localparam t_kind K_LBRACE    = 5'd2;
    localparam t_kind K_RBRACE    = 5'd3;
    localparam t_kind K_SEMI      = 5'd4;
    localparam t_kind K_COMMA     = 5'd5;
    localparam t_kind K_DOT       = 5'd6;
    localparam t_kind K_MINUS     = 5'd7;
    localparam t_kind K_PLUS      = 5'd8;
    localparam t_kind K_SLASH     = 5'd9;
    localparam t_kind K_STAR      = 5'd10;
    localparam t_kind K_OPER_BASE = 5'd11;
    localparam t_kind K_INT       = 5'd19;
    localparam t_kind K_DOUBLE    = 5'd20;
    localparam t_kind K_STRING    = 5'd21;
    localparam t_kind K_EOF       = 5'd22;
    localparam t_kind K_BAD       = 5'd23;
    localparam t_kind K_UNTERM    = 5'd24;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_LESS   = 8'h3C;
    localparam logic [7:0] CH_EQUAL  = 8'h3D;
    localparam logic [7:0] CH_GREAT  = 8'h3E;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    localparam t_oper OP_BANG  = 2'd0;
    localparam t_oper OP_EQUAL = 2'd1;
    localparam t_oper OP_LESS  = 2'd2;
    localparam t_oper OP_GREAT = 2'd3;

    typedef enum logic [3:0] {
        MODE_IDLE,
        MODE_INT,
        MODE_INT_DOT,
        MODE_FRAC,
        MODE_SLASH,
        MODE_OPER,
        MODE_STRING,
        MODE_COMMENT
    } t_scan_mode;

    typedef struct packed {
        t_kind  kind;
        t_field start;
        t_field length;
    } t_token;

    typedef struct packed {
        t_count                  count;
        t_field                  line;
        t_token [MAX_TOKENS-1:0] tokens;
    } t_bundle;

    typedef struct packed {
        logic  hit;
        t_kind kind;
    } t_lookup;

    typedef struct packed {
        logic  hit;
        t_oper index;
    } t_oper_lookup;

    function automatic t_pos span(t_pos from, t_pos to);
        return (to > from) ? t_pos'(to - from) : '0;
    endfunction

    function automatic t_field clip_pos(logic [POSITION_BITS:0] v);
        logic [POS_EXT_W-1:0] w;
        w = POS_EXT_W'(v);
        return (w > POS_EXT_W'(FIELD_MAX)) ? '1 : w[FIELD_BITS-1:0];
    endfunction

    function automatic t_field clip_line(t_line v);
        logic [LINE_EXT_W-1:0] w;
        w = LINE_EXT_W'(v);
        return (w > LINE_EXT_W'(FIELD_MAX)) ? '1 : w[FIELD_BITS-1:0];
    endfunction

    function automatic t_lookup punct_kind(logic [7:0] c);
        t_lookup r;
        r.hit = 1'b1;
        case (c)
            CH_LPAREN: r.kind = K_LPAREN;
            CH_RPAREN: r.kind = K_RPAREN;
            CH_LBRACE: r.kind = K_LBRACE;
            CH_RBRACE: r.kind = K_RBRACE;
            CH_SEMI:   r.kind = K_SEMI;
            CH_COMMA:  r.kind = K_COMMA;
            CH_DOT:    r.kind = K_DOT;
            CH_MINUS:  r.kind = K_MINUS;
            CH_PLUS:   r.kind = K_PLUS;
            CH_STAR:   r.kind = K_STAR;
            default: begin
                r.hit  = 1'b0;
                r.kind = K_BAD;
            end
        endcase
        return r;
    endfunction

    function automatic t_oper_lookup oper_index(logic [7:0] c);
        t_oper_lookup r;
        r.hit = 1'b1;
        case (c)
            CH_BANG:  r.index = OP_BANG;
            CH_EQUAL: r.index = OP_EQUAL;
            CH_LESS:  r.index = OP_LESS;
            CH_GREAT: r.index = OP_GREAT;
            default: begin
                r.hit   = 1'b0;
                r.index = OP_BANG;
            end
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/sts_if.sv
`default_nettype none

interface sts_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] source_byte;

    modport source (output valid, output source_byte, input ready);
    modport sink (input valid, input source_byte, output ready);
endinterface

interface sts_token_if;
    logic        valid;
    logic        ready;
    logic [4:0]  token_kind;
    logic [15:0] token_start;
    logic [15:0] token_length;
    logic [15:0] token_line;
    logic        last_of_run;

    modport source (
        output valid, output token_kind, output token_start, output token_length,
        output token_line, output last_of_run, input ready
    );
    modport sink (
        input valid, input token_kind, input token_start, input token_length,
        input token_line, input last_of_run, output ready
    );
endinterface

`default_nettype wire

>>> hw/rtl/sts_front.sv
`default_nettype none

module sts_front (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    sts_byte_if.sink              i_byte,
    output logic                  o_push_valid,
    input  wire logic             i_push_ready,
    output sts_pkg::t_bundle      o_bundle
);
    import sts_pkg::*;

    t_scan_mode r_mode, n_mode;
    t_oper      r_pend, n_pend;
    t_pos       r_start, n_start;
    t_pos       r_pos, n_pos;
    t_line      r_line, n_line;

    logic [7:0]   c;
    logic         accept;
    logic         is_digit, is_dot, is_slash, is_quote, is_eq, is_nl, is_nul, is_blank;
    logic         used;
    t_lookup      pk;
    t_oper_lookup ok;
    t_pos         run_len;
    t_pos         int_len;
    t_token       t0, t1, t2;
    t_count       cnt;

    assign c        = i_byte.source_byte;
    assign accept   = i_byte.valid && i_push_ready;
    assign is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
    assign is_dot   = (c == CH_DOT);
    assign is_slash = (c == CH_SLASH);
    assign is_quote = (c == CH_QUOTE);
    assign is_eq    = (c == CH_EQUAL);
    assign is_nl    = (c == CH_LF);
    assign is_nul   = (c == CH_NUL);
    assign is_blank = (c == CH_SPACE) || (c == CH_CR) || (c == CH_TAB);
    assign pk       = punct_kind(c);
    assign ok       = oper_index(c);
    assign run_len  = span(r_start, r_pos);
    assign int_len  = (run_len != '0) ? t_pos'(run_len - t_pos'(1)) : '0;

    assign used = ((r_mode == MODE_INT) && (is_digit || is_dot))
               || ((r_mode == MODE_INT_DOT) && is_digit)
               || ((r_mode == MODE_FRAC) && is_digit)
               || ((r_mode == MODE_SLASH) && is_slash)
               || ((r_mode == MODE_OPER) && is_eq)
               || ((r_mode == MODE_STRING) && !is_nul)
               || ((r_mode == MODE_COMMENT) && !(is_nl || is_nul));

    always_comb begin
        n_mode  = r_mode;
        n_pend  = r_pend;
        n_start = r_start;
        n_pos   = (r_pos != '1) ? t_pos'(r_pos + t_pos'(1)) : r_pos;
        n_line  = r_line;
        case (r_mode)
            MODE_INT: begin
                if (is_dot) begin
                    n_mode = MODE_INT_DOT;
                end else if (!is_digit) begin
                    n_mode = MODE_IDLE;
                end
            end
            MODE_INT_DOT: n_mode = is_digit ? MODE_FRAC : MODE_IDLE;
            MODE_FRAC:    n_mode = is_digit ? MODE_FRAC : MODE_IDLE;
            MODE_SLASH:   n_mode = is_slash ? MODE_COMMENT : MODE_IDLE;
            MODE_OPER:    n_mode = MODE_IDLE;
            MODE_STRING: begin
                if (is_quote || is_nul) begin
                    n_mode = MODE_IDLE;
                end
            end
            MODE_COMMENT: begin
                if (is_nl || is_nul) begin
                    n_mode = MODE_IDLE;
                end
            end
            default: n_mode = MODE_IDLE;
        endcase
        if (is_nl && (r_line != '1) && ((r_mode == MODE_STRING) || !used)) begin
            n_line = t_line'(r_line + t_line'(1));
        end
        if (!used) begin
            if (is_nul) begin
                n_mode  = MODE_IDLE;
                n_pend  = OP_BANG;
                n_start = '0;
                n_pos   = '0;
                n_line  = t_line'(1);
            end else if (is_digit) begin
                n_mode  = MODE_INT;
                n_start = r_pos;
            end else if (is_slash) begin
                n_mode  = MODE_SLASH;
                n_start = r_pos;
            end else if (is_quote) begin
                n_mode  = MODE_STRING;
                n_start = r_pos;
            end else if (ok.hit) begin
                n_mode  = MODE_OPER;
                n_pend  = ok.index;
                n_start = r_pos;
            end
        end
    end

    always_comb begin
        t_token a0, a1, b;
        logic [1:0] m;
        logic       b_hit;
        a0    = '{kind: K_INT, start: clip_pos({1'b0, r_start}),
                  length: clip_pos({1'b0, run_len})};
        a1    = '{kind: K_DOT, start: clip_pos({1'b0, t_pos'(r_start + int_len)}),
                  length: t_field'(1)};
        b     = '{kind: K_BAD, start: clip_pos({1'b0, r_pos}), length: t_field'(1)};
        m     = 2'd0;
        b_hit = 1'b0;
        case (r_mode)
            MODE_INT: begin
                if (!is_digit && !is_dot) begin
                    m = 2'd1;
                end
            end
            MODE_INT_DOT: begin
                if (!is_digit) begin
                    a0.length = clip_pos({1'b0, int_len});
                    m = 2'd2;
                end
            end
            MODE_FRAC: begin
                a0.kind = K_DOUBLE;
                if (!is_digit) begin
                    m = 2'd1;
                end
            end
            MODE_SLASH: begin
                a0.kind   = K_SLASH;
                a0.length = t_field'(1);
                if (!is_slash) begin
                    m = 2'd1;
                end
            end
            MODE_OPER: begin
                m = 2'd1;
                if (is_eq) begin
                    a0.kind   = t_kind'(K_OPER_BASE + {2'b00, r_pend, 1'b1});
                    a0.length = t_field'(2);
                end else begin
                    a0.kind   = t_kind'(K_OPER_BASE + {2'b00, r_pend, 1'b0});
                    a0.length = t_field'(1);
                end
            end
            MODE_STRING: begin
                if (is_quote) begin
                    a0.kind   = K_STRING;
                    a0.length = clip_pos(
                        (POSITION_BITS + 1)'(run_len) + (POSITION_BITS + 1)'(1));
                    m = 2'd1;
                end else if (is_nul) begin
                    a0.kind = K_UNTERM;
                    m = 2'd1;
                end
            end
            default: m = 2'd0;
        endcase
        if (!used) begin
            if (is_nul) begin
                b.kind   = K_EOF;
                b.length = '0;
                b_hit    = 1'b1;
            end else if (pk.hit) begin
                b.kind = pk.kind;
                b_hit  = 1'b1;
            end else if (!(is_blank || is_nl || is_digit || is_slash || is_quote || ok.hit)) begin
                b_hit = 1'b1;
            end
        end
        t0 = a0;
        t1 = a1;
        t2 = b;
        if (b_hit && (m == 2'd0)) begin
            t0 = b;
        end else if (b_hit && (m == 2'd1)) begin
            t1 = b;
        end
        cnt = t_count'(m) + t_count'(b_hit);
    end

    assign i_byte.ready    = i_push_ready;
    assign o_push_valid    = accept && (cnt != '0);
    assign o_bundle.count  = cnt;
    assign o_bundle.line   = clip_line(r_line);
    assign o_bundle.tokens = {t2, t1, t0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_IDLE;
            r_pend  <= OP_BANG;
            r_start <= '0;
            r_pos   <= '0;
            r_line  <= t_line'(1);
        end else if (accept) begin
            r_mode  <= n_mode;
            r_pend  <= n_pend;
            r_start <= n_start;
            r_pos   <= n_pos;
            r_line  <= n_line;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/sts_queue.sv
`default_nettype none

module sts_queue (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire sts_pkg::t_bundle i_bundle,
    output logic                  o_ready,
    output logic                  o_head_valid,
    output sts_pkg::t_bundle      o_head,
    input  wire logic             i_pop
);
    import sts_pkg::*;

    t_bundle               r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   r_wr, r_rd;
    logic [QUEUE_AW:0]     r_fill;
    logic                  do_push, do_pop;

    assign o_ready      = (r_fill != (QUEUE_AW + 1)'(QUEUE_DEPTH));
    assign o_head_valid = (r_fill != '0);
    assign o_head       = r_mem[r_rd];
    assign do_push      = i_push && o_ready;
    assign do_pop       = i_pop && o_head_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_bundle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr   <= '0;
            r_rd   <= '0;
            r_fill <= '0;
        end else begin
            if (do_push) begin
                r_wr <= QUEUE_AW'(r_wr + QUEUE_AW'(1));
            end
            if (do_pop) begin
                r_rd <= QUEUE_AW'(r_rd + QUEUE_AW'(1));
            end
            if (do_push && !do_pop) begin
                r_fill <= (QUEUE_AW + 1)'(r_fill + 1'b1);
            end else if (do_pop && !do_push) begin
                r_fill <= (QUEUE_AW + 1)'(r_fill - 1'b1);
            end
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/sts_back.sv
`default_nettype none

module sts_back (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_head_valid,
    input  wire sts_pkg::t_bundle i_head,
    output logic                  o_pop,
    sts_token_if.source           o_token
);
    import sts_pkg::*;

    t_count r_idx, n_idx;
    t_token cur;
    logic   last;
    logic   beat;

    assign cur  = i_head.tokens[r_idx];
    assign last = (r_idx == t_count'(i_head.count - t_count'(1)));
    assign beat = o_token.valid && o_token.ready;

    assign o_token.valid        = i_head_valid;
    assign o_token.token_kind   = cur.kind;
    assign o_token.token_start  = cur.start;
    assign o_token.token_length = cur.length;
    assign o_token.token_line   = i_head.line;
    assign o_token.last_of_run  = last;
    assign o_pop                = beat && last;

    always_comb begin
        n_idx = r_idx;
        if (beat) begin
            n_idx = last ? '0 : t_count'(r_idx + t_count'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else begin
            r_idx <= n_idx;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/source_token_scanner.sv
// Token scanner for a small source language.
// Source bytes enter on i_byte, one beat per byte; a byte of zero ends the
// source. Tokens leave on o_token, one beat per token, each with its kind,
// start offset, length and line; last_of_run marks the final token caused
// by one source byte, and one byte causes at most three tokens.
// The front scanner decides each byte in the cycle it is taken and needs no
// lookahead stall, so a byte is accepted in every cycle while the token
// queue has room. Its tokens are written to that queue and leave on
// o_token from there, one per cycle while the receiver is ready.
// A byte that closes a pending lexeme is the one that produces its token.
// The end-of-source byte flushes the pending token, emits the end token and
// returns offset, line and scan state to their initial values.
// When the receiver stalls, the four-entry queue, each entry holding the
// tokens of one byte, fills and i_byte.ready drops until an entry is freed.
// Reset empties the queue and starts scanning at offset zero on line one.
`default_nettype none

module source_token_scanner (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    sts_byte_if.sink    i_byte,
    sts_token_if.source o_token
);
    import sts_pkg::*;

    logic    push_valid;
    logic    push_ready;
    t_bundle push_bundle;
    logic    head_valid;
    t_bundle head;
    logic    pop;

    sts_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_byte       (i_byte),
        .o_push_valid (push_valid),
        .i_push_ready (push_ready),
        .o_bundle     (push_bundle)
    );

    sts_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push_valid),
        .i_bundle     (push_bundle),
        .o_ready      (push_ready),
        .o_head_valid (head_valid),
        .o_head       (head),
        .i_pop        (pop)
    );

    sts_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head       (head),
        .o_pop        (pop),
        .o_token      (o_token)
    );

endmodule

`default_nettype wire

>>> sim/tb.sv
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sts_pkg::*;

    localparam int HOLD_CYCLES      = 300;
    localparam int WATCHDOG_LIMIT   = 3000;
    localparam int RANDOM_BYTES     = 100;
    localparam int MAX_REPORTS      = 10;

    typedef struct {
        t_kind  kind;
        t_field start;
        t_field length;
        t_field line;
        logic   last;
    } t_exp_token;

    logic i_clk;
    logic i_rst_n;

    sts_byte_if  byte_bus ();
    sts_token_if token_bus ();

    source_token_scanner i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (byte_bus),
        .o_token (token_bus)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    t_exp_token expected_tokens[$];
    t_exp_token step_tokens[$];
    int     mismatches    = 0;
    int     bytes_sent    = 0;
    int     stall_count   = 0;
    int     hold_requests = 0;
    int     hold_served   = 0;
    int     hold_left     = 0;
    bit     idle_on       = 1'b1;

    t_scan_mode scan_state;
    t_oper      held_oper;
    t_pos       lexeme_at;
    t_pos       offset;
    t_line      line_no;

    function automatic t_field clip_field(longint v);
        return (v > FIELD_MAX) ? t_field'(FIELD_MAX) : t_field'(v);
    endfunction

    function automatic t_pos gap(t_pos from, t_pos to);
        return (to > from) ? t_pos'(to - from) : '0;
    endfunction

    function automatic bit is_digit(logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic void restart_scan();
        scan_state = MODE_IDLE;
        held_oper  = OP_BANG;
        lexeme_at  = '0;
        offset     = '0;
        line_no    = t_line'(1);
    endfunction

    function automatic void bump_line();
        if (line_no != '1) line_no++;
    endfunction

    function automatic void add_token(t_kind kind, longint start, longint length);
        t_exp_token t;
        if (step_tokens.size() >= MAX_TOKENS) return;
        t.kind   = kind;
        t.start  = clip_field(start);
        t.length = clip_field(length);
        t.line   = clip_field(longint'(line_no));
        t.last   = 1'b0;
        step_tokens.push_back(t);
    endfunction

    function automatic void begin_lexeme(t_scan_mode mode, t_pos p);
        scan_state = mode;
        lexeme_at  = p;
    endfunction

    function automatic void predict_byte(logic [7:0] c);
        t_pos p;
        t_pos n;
        bit   used;
        bit   at_end;
        p      = offset;
        used   = 1'b0;
        at_end = 1'b0;
        step_tokens.delete();
        case (scan_state)
            MODE_INT: begin
                if (is_digit(c)) begin
                    used = 1'b1;
                end else if (c == CH_DOT) begin
                    scan_state = MODE_INT_DOT;
                    used = 1'b1;
                end else begin
                    add_token(K_INT, lexeme_at, gap(lexeme_at, p));
                    scan_state = MODE_IDLE;
                end
            end
            MODE_INT_DOT: begin
                if (is_digit(c)) begin
                    scan_state = MODE_FRAC;
                    used = 1'b1;
                end else begin
                    n = gap(lexeme_at, p);
                    n = (n > 0) ? t_pos'(n - 1) : '0;
                    add_token(K_INT, lexeme_at, n);
                    add_token(K_DOT, longint'(lexeme_at) + longint'(n), 1);
                    scan_state = MODE_IDLE;
                end
            end
            MODE_FRAC: begin
                if (is_digit(c)) begin
                    used = 1'b1;
                end else begin
                    add_token(K_DOUBLE, lexeme_at, gap(lexeme_at, p));
                    scan_state = MODE_IDLE;
                end
            end
            MODE_SLASH: begin
                if (c == CH_SLASH) begin
                    scan_state = MODE_COMMENT;
                    used = 1'b1;
                end else begin
                    add_token(K_SLASH, lexeme_at, 1);
                    scan_state = MODE_IDLE;
                end
            end
            MODE_OPER: begin
                if (c == CH_EQUAL) begin
                    add_token(t_kind'(K_OPER_BASE + 2 * held_oper + 1), lexeme_at, 2);
                    used = 1'b1;
                end else begin
                    add_token(t_kind'(K_OPER_BASE + 2 * held_oper), lexeme_at, 1);
                end
                scan_state = MODE_IDLE;
            end
            MODE_STRING: begin
                if (c == CH_QUOTE) begin
                    add_token(K_STRING, lexeme_at, longint'(gap(lexeme_at, p)) + 1);
                    scan_state = MODE_IDLE;
                    used = 1'b1;
                end else if (c == CH_NUL) begin
                    add_token(K_UNTERM, lexeme_at, gap(lexeme_at, p));
                    scan_state = MODE_IDLE;
                end else begin
                    if (c == CH_LF) bump_line();
                    used = 1'b1;
                end
            end
            MODE_COMMENT: begin
                if (c == CH_LF || c == CH_NUL) scan_state = MODE_IDLE;
                else used = 1'b1;
            end
            default: scan_state = MODE_IDLE;
        endcase
        if (!used) begin
            case (c)
                CH_NUL: begin
                    add_token(K_EOF, p, 0);
                    restart_scan();
                    at_end = 1'b1;
                end
                CH_SPACE, CH_CR, CH_TAB: ;
                CH_LF:     bump_line();
                CH_SLASH:  begin_lexeme(MODE_SLASH, p);
                CH_QUOTE:  begin_lexeme(MODE_STRING, p);
                CH_BANG: begin
                    begin_lexeme(MODE_OPER, p);
                    held_oper = OP_BANG;
                end
                CH_EQUAL: begin
                    begin_lexeme(MODE_OPER, p);
                    held_oper = OP_EQUAL;
                end
                CH_LESS: begin
                    begin_lexeme(MODE_OPER, p);
                    held_oper = OP_LESS;
                end
                CH_GREAT: begin
                    begin_lexeme(MODE_OPER, p);
                    held_oper = OP_GREAT;
                end
                CH_LPAREN: add_token(K_LPAREN, p, 1);
                CH_RPAREN: add_token(K_RPAREN, p, 1);
                CH_LBRACE: add_token(K_LBRACE, p, 1);
                CH_RBRACE: add_token(K_RBRACE, p, 1);
                CH_SEMI:   add_token(K_SEMI, p, 1);
                CH_COMMA:  add_token(K_COMMA, p, 1);
                CH_DOT:    add_token(K_DOT, p, 1);
                CH_MINUS:  add_token(K_MINUS, p, 1);
                CH_PLUS:   add_token(K_PLUS, p, 1);
                CH_STAR:   add_token(K_STAR, p, 1);
                default: begin
                    if (is_digit(c)) begin_lexeme(MODE_INT, p);
                    else add_token(K_BAD, p, 1);
                end
            endcase
        end
        if (!at_end && offset != '1) offset++;
        if (step_tokens.size() > 0) step_tokens[step_tokens.size() - 1].last = 1'b1;
        foreach (step_tokens[i]) expected_tokens.push_back(step_tokens[i]);
    endfunction

    function automatic void log_failure(string what, t_exp_token want, t_exp_token got,
                                        bit with_want);
        string seen;
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
            seen = $sformatf("got kind %0d start %0d length %0d line %0d last %0b",
                             got.kind, got.start, got.length, got.line, got.last);
            if (with_want) begin
                $display("%s: expected kind %0d start %0d length %0d line %0d last %0b, %s",
                         what, want.kind, want.start, want.length, want.line, want.last,
                         seen);
            end else begin
                $display("%s: %s", what, seen);
            end
        end
    endfunction

    always @(posedge i_clk) begin
        t_exp_token got;
        t_exp_token want;
        if (i_rst_n && token_bus.valid && token_bus.ready) begin
            got.kind   = token_bus.token_kind;
            got.start  = token_bus.token_start;
            got.length = token_bus.token_length;
            got.line   = token_bus.token_line;
            got.last   = token_bus.last_of_run;
            if (expected_tokens.size() == 0) begin
                log_failure("token with none expected", got, got, 1'b0);
            end else begin
                want = expected_tokens.pop_front();
                if (got.kind !== want.kind || got.start !== want.start ||
                    got.length !== want.length || got.line !== want.line ||
                    got.last !== want.last) begin
                    log_failure("token mismatch", want, got, 1'b1);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            token_bus.ready <= 1'b0;
            hold_left = hold_left - 1;
        end else if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            hold_left = HOLD_CYCLES - 1;
            token_bus.ready <= 1'b0;
        end else begin
            token_bus.ready <= idle_on ? ($urandom_range(0, 99) >= 34) : 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (byte_bus.valid && byte_bus.ready) ||
            (token_bus.valid && token_bus.ready)) begin
            stall_count <= 0;
        end else if (stall_count >= WATCHDOG_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end else begin
            stall_count <= stall_count + 1;
        end
    end

    task automatic send_byte(input logic [7:0] c);
        while (idle_on && $urandom_range(0, 99) < 34) begin
            byte_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        byte_bus.valid <= 1'b1;
        byte_bus.source_byte <= c;
        do begin
            @(posedge i_clk);
        end while (!byte_bus.ready);
        predict_byte(c);
        bytes_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    endtask

    task automatic wait_drained();
        byte_bus.valid <= 1'b0;
        @(posedge i_clk);
        while (expected_tokens.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [7:0] random_digit();
        return 8'($urandom_range(CH_ZERO, CH_NINE));
    endfunction

    function automatic logic [7:0] random_punct();
        case ($urandom_range(0, 10))
            0:       return CH_LPAREN;
            1:       return CH_RPAREN;
            2:       return CH_LBRACE;
            3:       return CH_RBRACE;
            4:       return CH_SEMI;
            5:       return CH_COMMA;
            6:       return CH_DOT;
            7:       return CH_MINUS;
            8:       return CH_PLUS;
            9:       return CH_SLASH;
            default: return CH_STAR;
        endcase
    endfunction

    function automatic logic [7:0] random_oper();
        case ($urandom_range(0, 3))
            0:       return CH_BANG;
            1:       return CH_EQUAL;
            2:       return CH_LESS;
            default: return CH_GREAT;
        endcase
    endfunction

    function automatic logic [7:0] random_blank();
        case ($urandom_range(0, 3))
            0:       return CH_SPACE;
            1:       return CH_TAB;
            2:       return CH_CR;
            default: return CH_LF;
        endcase
    endfunction

    function automatic logic [7:0] random_text_char(logic [7:0] stop);
        logic [7:0] c;
        c = 8'($urandom_range(1, 255));
        if (c == stop) c = CH_SPACE;
        return c;
    endfunction

    task automatic send_random_lexeme();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 15) begin
            repeat ($urandom_range(1, 3)) send_byte(random_digit());
        end else if (pick < 23) begin
            repeat ($urandom_range(1, 2)) send_byte(random_digit());
            send_byte(CH_DOT);
            repeat ($urandom_range(1, 2)) send_byte(random_digit());
        end else if (pick < 27) begin
            send_byte(random_digit());
            send_byte(CH_DOT);
        end else if (pick < 37) begin
            send_byte(CH_QUOTE);
            repeat ($urandom_range(0, 5)) begin
                if ($urandom_range(0, 5) == 0) send_byte(CH_LF);
                else send_byte(random_text_char(CH_QUOTE));
            end
            if ($urandom_range(0, 9) != 0) send_byte(CH_QUOTE);
        end else if (pick < 42) begin
            send_byte(CH_SLASH);
            send_byte(CH_SLASH);
            repeat ($urandom_range(0, 4)) send_byte(random_text_char(CH_LF));
            send_byte(CH_LF);
        end else if (pick < 57) begin
            send_byte(random_punct());
        end else if (pick < 70) begin
            send_byte(random_oper());
            if ($urandom_range(0, 1) == 1) send_byte(CH_EQUAL);
        end else if (pick < 83) begin
            send_byte(random_blank());
        end else begin
            send_byte(8'($urandom_range(1, 255)));
        end
        if ($urandom_range(0, 1) == 1) send_byte(CH_SPACE);
    endtask

    task automatic test_punctuators();
        send_byte(CH_NUL);
        send_text("(){};,.-+/*");
        send_byte(8'hFF);
        send_byte(CH_NUL);
    endtask

    task automatic test_operators();
        send_text("===!=!<=<>=>");
        send_byte(CH_NUL);
    endtask

    task automatic test_numbers();
        send_text("12.5\t7.x");
        send_byte(CH_CR);
        send_text("3 5.");
        send_byte(CH_NUL);
    endtask

    task automatic test_strings_and_comments();
        send_text("\"a\nb\"//c\n\"z");
        send_byte(CH_NUL);
        send_byte(CH_SLASH);
        send_byte(CH_NUL);
        send_text("//");
        send_byte(CH_NUL);
    endtask

    // The receiver stops long enough for the token queue to fill and the byte input to stall.
    task automatic test_back_pressure();
        idle_on = 1'b0;
        hold_requests++;
        repeat (6) send_text("(){}");
        send_byte(CH_NUL);
        wait_drained();
        idle_on = 1'b1;
    endtask

    task automatic test_random_sources();
        int first_byte;
        int program_start;
        int program_len;
        first_byte = bytes_sent;
        while (bytes_sent - first_byte < RANDOM_BYTES) begin
            idle_on = !((bytes_sent - first_byte > RANDOM_BYTES / 3) &&
                        (bytes_sent - first_byte < 2 * RANDOM_BYTES / 3));
            program_len = $urandom_range(4, 30);
            program_start = bytes_sent;
            while (bytes_sent - program_start < program_len) send_random_lexeme();
            send_byte(CH_NUL);
            if ($urandom_range(0, 3) == 0) wait_drained();
        end
        idle_on = 1'b1;
    endtask

    initial begin
        i_rst_n <= 1'b0;
        byte_bus.valid <= 1'b0;
        byte_bus.source_byte <= CH_NUL;
        restart_scan();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_punctuators();
        test_operators();
        test_numbers();
        test_strings_and_comments();
        test_back_pressure();
        test_random_sources();
        wait_drained();
        repeat (20) @(posedge i_clk);
        if (expected_tokens.size() != 0) begin
            mismatches += expected_tokens.size();
            $display("%0d expected tokens never arrived", expected_tokens.size());
        end
        if (mismatches == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

`default_nettype wire

>>> files.f
hw/rtl/sts_pkg.sv
hw/rtl/sts_if.sv
hw/rtl/sts_front.sv
hw/rtl/sts_queue.sv
hw/rtl/sts_back.sv
hw/rtl/source_token_scanner.sv
sim/tb.sv
